[rtl/xmrx_pkg.sv]
// Shared types, protocol byte codes and the CRC-16 byte update for the XMODEM receiver.
package xmrx_pkg;

    // Block sizes and trailer constants
    localparam logic [10:0] LARGE_BLOCK = 11'd1024;
    localparam logic [10:0] SMALL_BLOCK = 11'd128;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  NUM_MASK    = 8'hFF;

    // Reset values of the configuration registers
    localparam logic       USE_CRC_RST     = 1'b1;
    localparam logic [7:0] MAX_RETRIES_RST = 8'd10;

    // Configuration register indexes
    localparam logic [7:0] CFG_USE_CRC     = 8'd0;
    localparam logic [7:0] CFG_MAX_RETRIES = 8'd1;

    // Line characters
    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_CST = 8'h43;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_BYTE    = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_CANCEL  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_NUM  = 3'd1,
        PH_COMP = 3'd2,
        PH_DATA = 3'd3,
        PH_CHK1 = 3'd4,
        PH_CHK2 = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_WAIT = 3'd1,
        ST_XFER = 3'd2,
        ST_DONE = 3'd3,
        ST_CANC = 3'd4,
        ST_ERR  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        VD_NONE   = 2'd0,
        VD_COMMIT = 2'd1,
        VD_REJECT = 2'd2
    } t_verdict;

    // One result item as it leaves the control core
    typedef struct packed {
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [9:0] payload_offset;
        t_verdict   packet_verdict;
        logic [7:0] packet_index;
        logic       large_block;
        t_status    transfer_status;
        logic [7:0] retries_used;
        logic       repeat3;        // cancel: the item yields three identical results
    } t_result;

    // Bytewise CRC-16, MSB first, poly 0x1021
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/xmrx_ctrl.sv]
// Receiver control core: protocol state, config registers and per-request result logic.
module xmrx_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,       // request moves from input to result register
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_byte,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output xmrx_pkg::t_result o_result
);

    xmrx_pkg::t_phase  r_phase,  n_phase;
    xmrx_pkg::t_status r_status, n_status;
    logic [7:0]  r_exp_num,  n_exp_num;
    logic [7:0]  r_got_num,  n_got_num;
    logic [7:0]  r_got_comp, n_got_comp;
    logic        r_large,    n_large;
    logic [10:0] r_offset,   n_offset;
    logic [15:0] r_crc,      n_crc;
    logic [7:0]  r_sum,      n_sum;
    logic [7:0]  r_chk_high, n_chk_high;
    logic [7:0]  r_retry,    n_retry;
    logic        r_use_crc;
    logic [7:0]  r_max_retries;

    xmrx_pkg::t_op op;
    logic        active;
    logic        retry_over;
    logic [7:0]  retry_inc;
    logic [10:0] offset_inc;
    logic        data_end;
    logic        judge_ev;
    logic        chk_ok;
    logic        num_ok;
    logic        pkt_accept;
    logic        pkt_dup;
    logic [7:0]  start_char;

    // Shared decode and packet judgment
    always_comb begin
        op         = xmrx_pkg::t_op'(i_op);
        active     = r_status inside {xmrx_pkg::ST_WAIT, xmrx_pkg::ST_XFER};
        retry_over = r_retry >= r_max_retries;
        retry_inc  = (r_retry == 8'hFF) ? r_retry : r_retry + 8'd1;
        offset_inc = r_offset + 11'd1;
        data_end   = offset_inc >= (r_large ? xmrx_pkg::LARGE_BLOCK : xmrx_pkg::SMALL_BLOCK);
        start_char = r_use_crc ? xmrx_pkg::B_CST : xmrx_pkg::B_NAK;
        judge_ev   = (op == xmrx_pkg::OP_BYTE) && active &&
                     (((r_phase == xmrx_pkg::PH_CHK1) && !r_use_crc) ||
                      (r_phase == xmrx_pkg::PH_CHK2));
        if (r_phase == xmrx_pkg::PH_CHK1) begin
            chk_ok = (i_byte == r_sum);
        end else begin
            chk_ok = !r_use_crc || ({r_chk_high, i_byte} == r_crc);
        end
        num_ok     = (r_got_num ^ r_got_comp) == xmrx_pkg::NUM_MASK;
        pkt_accept = num_ok && chk_ok && (r_got_num == r_exp_num);
        pkt_dup    = num_ok && chk_ok && !pkt_accept && (r_got_num == r_exp_num - 8'd1);
    end

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_status   = r_status;
        n_exp_num  = r_exp_num;
        n_got_num  = r_got_num;
        n_got_comp = r_got_comp;
        n_large    = r_large;
        n_offset   = r_offset;
        n_crc      = r_crc;
        n_sum      = r_sum;
        n_chk_high = r_chk_high;
        n_retry    = r_retry;
        case (op)
            xmrx_pkg::OP_START: begin
                if (!active) begin
                    n_exp_num = 8'd1;
                    n_retry   = '0;
                    n_phase   = xmrx_pkg::PH_HUNT;
                    n_status  = xmrx_pkg::ST_WAIT;
                end
            end
            xmrx_pkg::OP_BYTE: begin
                if (active) begin
                    case (r_phase)
                        xmrx_pkg::PH_HUNT: begin
                            if (i_byte == xmrx_pkg::B_EOT) begin
                                n_status = xmrx_pkg::ST_DONE;
                            end else if (i_byte == xmrx_pkg::B_CAN) begin
                                n_status = xmrx_pkg::ST_CANC;
                            end else if (i_byte inside {xmrx_pkg::B_SOH, xmrx_pkg::B_STX}) begin
                                n_large = (i_byte == xmrx_pkg::B_STX);
                                n_phase = xmrx_pkg::PH_NUM;
                            end
                        end
                        xmrx_pkg::PH_NUM: begin
                            n_got_num = i_byte;
                            n_phase   = xmrx_pkg::PH_COMP;
                        end
                        xmrx_pkg::PH_COMP: begin
                            n_got_comp = i_byte;
                            n_offset   = '0;
                            n_crc      = '0;
                            n_sum      = '0;
                            n_phase    = xmrx_pkg::PH_DATA;
                        end
                        xmrx_pkg::PH_DATA: begin
                            n_crc    = xmrx_pkg::crc16_byte(r_crc, i_byte);
                            n_sum    = r_sum + i_byte;
                            n_offset = offset_inc;
                            if (data_end) begin
                                n_phase = xmrx_pkg::PH_CHK1;
                            end
                        end
                        xmrx_pkg::PH_CHK1: begin
                            n_chk_high = i_byte;
                            n_phase    = r_use_crc ? xmrx_pkg::PH_CHK2 : xmrx_pkg::PH_HUNT;
                        end
                        xmrx_pkg::PH_CHK2: begin
                            n_phase = xmrx_pkg::PH_HUNT;
                        end
                        default: begin
                            n_phase = xmrx_pkg::PH_HUNT;
                        end
                    endcase
                    // trailer complete: verdict bookkeeping
                    if (judge_ev) begin
                        if (pkt_accept) begin
                            n_exp_num = r_exp_num + 8'd1;
                            n_retry   = '0;
                            n_status  = xmrx_pkg::ST_XFER;
                        end else if (pkt_dup) begin
                            n_retry = '0;
                        end else begin
                            n_retry = retry_inc;
                            if (retry_over) begin
                                n_status = xmrx_pkg::ST_ERR;
                            end
                        end
                    end
                end
            end
            xmrx_pkg::OP_TIMEOUT: begin
                if (active) begin
                    n_phase = xmrx_pkg::PH_HUNT;
                    n_retry = retry_inc;
                    if (retry_over) begin
                        n_status = xmrx_pkg::ST_ERR;
                    end
                end
            end
            xmrx_pkg::OP_CANCEL: begin
                n_phase  = xmrx_pkg::PH_HUNT;
                n_status = xmrx_pkg::ST_CANC;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Result fields
    always_comb begin
        o_result                 = '0;
        o_result.packet_verdict  = xmrx_pkg::VD_NONE;
        o_result.large_block     = n_large;
        o_result.transfer_status = n_status;
        o_result.retries_used    = n_retry;
        case (op)
            xmrx_pkg::OP_START: begin
                if (!active) begin
                    o_result.reply_valid = 1'b1;
                    o_result.reply_byte  = start_char;
                end
            end
            xmrx_pkg::OP_BYTE: begin
                if (active && (r_phase == xmrx_pkg::PH_HUNT) &&
                    (i_byte == xmrx_pkg::B_EOT)) begin
                    o_result.reply_valid = 1'b1;
                    o_result.reply_byte  = xmrx_pkg::B_ACK;
                end
                if (active && (r_phase == xmrx_pkg::PH_DATA)) begin
                    o_result.payload_valid  = 1'b1;
                    o_result.payload_byte   = i_byte;
                    o_result.payload_offset = r_offset[9:0];
                end
                if (judge_ev) begin
                    o_result.packet_index   = r_got_num;
                    o_result.packet_verdict = pkt_accept ? xmrx_pkg::VD_COMMIT
                                                         : xmrx_pkg::VD_REJECT;
                    if (pkt_accept || pkt_dup) begin
                        o_result.reply_valid = 1'b1;
                        o_result.reply_byte  = xmrx_pkg::B_ACK;
                    end else if (!retry_over) begin
                        o_result.reply_valid = 1'b1;
                        o_result.reply_byte  = xmrx_pkg::B_NAK;
                    end
                end
            end
            xmrx_pkg::OP_TIMEOUT: begin
                if (active && !retry_over) begin
                    o_result.reply_valid = 1'b1;
                    o_result.reply_byte  = start_char;
                end
            end
            xmrx_pkg::OP_CANCEL: begin
                o_result.reply_valid = 1'b1;
                o_result.reply_byte  = xmrx_pkg::B_CAN;
                o_result.repeat3     = 1'b1;
            end
            default: begin
                o_result.reply_valid = 1'b0;
            end
        endcase
    end

    // Protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= xmrx_pkg::PH_HUNT;
            r_status   <= xmrx_pkg::ST_IDLE;
            r_exp_num  <= 8'd1;
            r_got_num  <= '0;
            r_got_comp <= '0;
            r_large    <= 1'b0;
            r_offset   <= '0;
            r_crc      <= '0;
            r_sum      <= '0;
            r_chk_high <= '0;
            r_retry    <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_status   <= n_status;
            r_exp_num  <= n_exp_num;
            r_got_num  <= n_got_num;
            r_got_comp <= n_got_comp;
            r_large    <= n_large;
            r_offset   <= n_offset;
            r_crc      <= n_crc;
            r_sum      <= n_sum;
            r_chk_high <= n_chk_high;
            r_retry    <= n_retry;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_crc     <= xmrx_pkg::USE_CRC_RST;
            r_max_retries <= xmrx_pkg::MAX_RETRIES_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == xmrx_pkg::CFG_USE_CRC) begin
                r_use_crc <= i_cfg_data[0];
            end else if (i_cfg_index == xmrx_pkg::CFG_MAX_RETRIES) begin
                r_max_retries <= i_cfg_data;
            end
        end
    end

endmodule

[rtl/xmodem_receiver_unit.sv]
// Top level of the XMODEM receiver: stream ports, input register and result register.
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid / s_axis_tready    tuser = operation, tdata = rx_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready    tdata = result fields, tlast = last
//  cfg       in   i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
//  One request per cycle while m_axis takes every beat and no cancel repeat is pending; a
//  result passes the input register, then the result register, before it reaches m_axis.
//  The CRC byte update is computed combinationally from the input register.
//  Cancel yields three results, holding the input side for two extra output beats.
//  Reset (synchronous, active low) empties both registers and sets the transfer idle.
//  A stalled output fills the input register, then s_axis_tready drops.
module xmodem_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [0] reply_valid, [8:1] reply_byte,
                                        // [9] payload_valid, [17:10] payload_byte,
                                        // [27:18] payload_offset, [29:28] packet_verdict,
                                        // [37:30] packet_index, [38] large_block,
                                        // [41:39] transfer_status, [49:42] retries_used,
                                        // [55:50] zero
    output logic        m_axis_tlast,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic              r_in_valid;
    logic [1:0]        r_in_op;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    logic [1:0]        r_out_rep;    // beats left after the current one
    xmrx_pkg::t_result r_out;
    xmrx_pkg::t_result w_result;
    logic              out_free;
    logic              step;

    // Handshake plumbing
    assign out_free      = !r_out_valid || (m_axis_tready && (r_out_rep == 2'd0));
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;
    assign o_cfg_ready   = 1'b1;

    xmrx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_op        (r_in_op),
        .i_byte      (r_in_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (w_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    // Result register with cancel repeat count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_rep   <= '0;
        end else if (step) begin
            r_out_valid <= 1'b1;
            r_out_rep   <= w_result.repeat3 ? 2'd2 : 2'd0;
        end else if (r_out_valid && m_axis_tready) begin
            if (r_out_rep != 2'd0) begin
                r_out_rep <= r_out_rep - 2'd1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = (r_out_rep == 2'd0);
    assign m_axis_tdata  = {6'd0, r_out.retries_used, r_out.transfer_status,
                            r_out.large_block, r_out.packet_index, r_out.packet_verdict,
                            r_out.payload_offset, r_out.payload_byte, r_out.payload_valid,
                            r_out.reply_byte, r_out.reply_valid};

    // Cancel repeats only ever carry CAN
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_rep != 2'd0)) |->
            (r_out.reply_valid && (r_out.reply_byte == xmrx_pkg::B_CAN)))
        else $error("repeated beat is not a CAN reply");

    // A payload byte never comes with a reply or a verdict
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.payload_valid) |->
            (!r_out.reply_valid && (r_out.packet_verdict == xmrx_pkg::VD_NONE)))
        else $error("payload beat carries a reply or a verdict");

    // A held request is not lost while the result side is blocked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_op) && $stable(r_in_byte)))
        else $error("pending request dropped or changed");

    // Input side only stalls behind a full input register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room available");

    // A repeat count only follows a loaded cancel
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_rep != 2'd0) |-> r_out_valid)
        else $error("repeat count without a result");

endmodule
